// ===== design/pprle_pkg.sv =====
package pprle_pkg;

	typedef logic [3:0] pix_t;
	typedef logic [2:0] didx_t;

	localparam int SCALE_SHIFT = 20;
	localparam int RECIP_W = 24;
	localparam int PROD_W = 8 + RECIP_W;

	function automatic logic [RECIP_W-1:0] pprle_recip(input didx_t idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			3'd0: r = 24'd15728640;
			3'd1: r = 24'd5242880;
			3'd2: r = 24'd2246949;
			3'd3: r = 24'd1048576;
			3'd4: r = 24'd507376;
			3'd5: r = 24'd249661;
			3'd6: r = 24'd123848;
			3'd7: r = 24'd61681;
			default: r = 24'd61681;
		endcase
		return r;
	endfunction

endpackage

// ===== design/pprle_scale.sv =====
module pprle_scale import pprle_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [7:0]  value,
	input  didx_t       depth_idx,
	output pix_t        scaled
);

	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(value) * PROD_W'(pprle_recip(depth_idx));
		end
	end

	assign scaled = prod_s1[SCALE_SHIFT+3:SCALE_SHIFT];

endmodule

// ===== design/packed_pixel_rle_unpacker_core.sv =====
// Unpacks 16-bit bitmap words into groups of 4-bit gray pixels, either as packed
// pixels of 1 to 8 bits scaled to 0..15 or as byte runs (high nibble + 1 pixels of
// the low-nibble value). The block takes one word at a time and holds in_stall high
// until that word is done. A packed word is accepted, then every pixel passes the
// shared extract shifter and then the scaling multiplier, and after the end-of-word
// check the last group is closed; an RLE word is accepted, then sends its run pixels
// and closes the last group. A finished group waits in a pending register and moves
// to the output register when the next group is finished or the word closes; the
// sequencer waits whenever it must hand over a group while that register is still stalled.
module packed_pixel_rle_unpacker_core import pprle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] source_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_group,
	output logic        last_of_input,
	output logic        last_of_image
);

	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_RLE   = 2'd1;
	localparam logic [1:0] REG_GROUP = 2'd2;
	localparam logic [1:0] REG_TOTAL = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXTRACT,
		S_SCALE,
		S_RUN,
		S_FLUSH
	} state_t;

	state_t      state_q;
	logic [3:0]  depth_cfg_q;
	logic        rle_mode_q;
	logic [2:0]  group_cfg_q;
	logic [15:0] pixel_total_q;

	logic [15:0] held_word_q;
	logic [4:0]  bits_rem_q;
	logic [31:0] buf_q;
	logic [4:0]  nbits_q;
	logic        byte_q;
	pix_t        run_val_q;
	logic [4:0]  run_rem_q;
	logic [15:0] acc_q;
	logic [2:0]  fill_q;
	logic [15:0] emitted_q;

	logic        pend_valid_q;
	logic [15:0] pend_group_q;
	logic        pend_done_q;

	logic        out_valid_q;
	logic [15:0] out_group_q;
	logic        out_last_in_q;
	logic        out_last_img_q;

	logic [3:0]  depth;
	didx_t       depth_idx;
	logic [7:0]  mask;
	logic [2:0]  group_size;
	logic [4:0]  shift;
	logic [7:0]  field;
	logic        have_bits;
	logic        scale_en;
	pix_t        scaled;
	logic [3:0]  keep_bits;
	logic [15:0] held_masked;

	logic        accept;
	logic        slot_free;
	logic        push_req;
	pix_t        pix;
	logic [15:0] acc_n;
	logic [2:0]  fill_n;
	logic [15:0] emitted_n;
	logic        done;
	logic        emit;
	logic        push_ok;

	always_comb begin
		depth = depth_cfg_q;
		if (depth_cfg_q == 4'd0) begin
			depth = 4'd1;
		end else if (depth_cfg_q > 4'd8) begin
			depth = 4'd8;
		end
		group_size = group_cfg_q;
		if (group_cfg_q == 3'd0) begin
			group_size = 3'd1;
		end else if (group_cfg_q > 3'd4) begin
			group_size = 3'd4;
		end
	end

	assign depth_idx = didx_t'(depth - 4'd1);
	assign mask      = 8'((9'd1 << depth) - 9'd1);
	assign have_bits = nbits_q >= 5'(depth);
	assign shift     = nbits_q - 5'(depth);
	assign field     = 8'(buf_q >> shift) & mask;
	assign scale_en  = (state_q == S_EXTRACT) && have_bits;

	assign keep_bits   = (bits_rem_q > 5'd15) ? 4'd15 : bits_rem_q[3:0];
	assign held_masked = held_word_q & ((16'd1 << keep_bits) - 16'd1);

	pprle_scale u_scale (
		.clk       (clk),
		.en        (scale_en),
		.value     (field),
		.depth_idx (depth_idx),
		.scaled    (scaled)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign push_req  = (state_q == S_RUN) || (state_q == S_SCALE);
	assign pix       = (state_q == S_RUN) ? run_val_q : scaled;
	assign acc_n     = {acc_q[11:0], pix};
	assign fill_n    = fill_q + 3'd1;
	assign emitted_n = emitted_q + 16'd1;
	assign done      = emitted_n >= pixel_total_q;
	assign emit      = (fill_n >= group_size) || done;
	assign push_ok   = push_req && (!emit || !pend_valid_q || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_cfg_q    <= 4'd4;
			rle_mode_q     <= 1'b0;
			group_cfg_q    <= 3'd1;
			pixel_total_q  <= 16'd0;
			held_word_q    <= 16'd0;
			bits_rem_q     <= 5'd0;
			buf_q          <= 32'd0;
			nbits_q        <= 5'd0;
			byte_q         <= 1'b0;
			run_val_q      <= '0;
			run_rem_q      <= 5'd0;
			acc_q          <= 16'd0;
			fill_q         <= 3'd0;
			emitted_q      <= 16'd0;
			pend_valid_q   <= 1'b0;
			pend_group_q   <= 16'd0;
			pend_done_q    <= 1'b0;
			out_valid_q    <= 1'b0;
			out_group_q    <= 16'd0;
			out_last_in_q  <= 1'b0;
			out_last_img_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEPTH: depth_cfg_q   <= cfg_data[3:0];
					REG_RLE:   rle_mode_q    <= cfg_data[0];
					REG_GROUP: group_cfg_q   <= cfg_data[2:0];
					REG_TOTAL: pixel_total_q <= cfg_data;
					default:   ;
				endcase
			end

			if (slot_free) begin
				out_valid_q <= 1'b0;
			end

			if (push_ok) begin
				emitted_q <= emitted_n;
				if (emit) begin
					acc_q        <= 16'd0;
					fill_q       <= 3'd0;
					pend_valid_q <= 1'b1;
					pend_group_q <= acc_n;
					pend_done_q  <= done;
					if (pend_valid_q) begin
						out_valid_q    <= 1'b1;
						out_group_q    <= pend_group_q;
						out_last_in_q  <= 1'b0;
						out_last_img_q <= pend_done_q;
					end
				end else begin
					acc_q  <= acc_n;
					fill_q <= fill_n;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept && (emitted_q < pixel_total_q)) begin
						if (rle_mode_q) begin
							buf_q     <= {16'd0, source_word};
							byte_q    <= 1'b0;
							run_val_q <= source_word[3:0];
							run_rem_q <= {1'b0, source_word[7:4]} + 5'd1;
							state_q   <= S_RUN;
						end else begin
							buf_q       <= {held_masked, source_word};
							nbits_q     <= 5'(keep_bits) + 5'd16;
							held_word_q <= source_word;
							state_q     <= S_EXTRACT;
						end
					end
				end
				S_EXTRACT: begin
					if (have_bits) begin
						nbits_q <= shift;
						state_q <= S_SCALE;
					end else begin
						bits_rem_q <= nbits_q;
						state_q    <= S_FLUSH;
					end
				end
				S_SCALE: begin
					if (push_ok) begin
						if (done) begin
							bits_rem_q <= (nbits_q > 5'd16) ? 5'd16 : nbits_q;
							state_q    <= S_FLUSH;
						end else begin
							state_q <= S_EXTRACT;
						end
					end
				end
				S_RUN: begin
					if (push_ok) begin
						if (done) begin
							state_q <= S_FLUSH;
						end else if (run_rem_q == 5'd1) begin
							if (!byte_q) begin
								byte_q    <= 1'b1;
								run_val_q <= buf_q[11:8];
								run_rem_q <= {1'b0, buf_q[15:12]} + 5'd1;
							end else begin
								state_q <= S_FLUSH;
							end
						end else begin
							run_rem_q <= run_rem_q - 5'd1;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						out_valid_q    <= 1'b1;
						out_group_q    <= pend_group_q;
						out_last_in_q  <= 1'b1;
						out_last_img_q <= pend_done_q;
						pend_valid_q   <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_group   = out_group_q;
	assign last_of_input = out_last_in_q;
	assign last_of_image = out_last_img_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("group left pending while idle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && emit |=> (fill_q == 3'd0) && pend_valid_q)
		else $error("emitted group not moved to pending");

	a_close_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) && pend_valid_q && slot_free
		|=> (state_q == S_IDLE) && out_valid && last_of_input)
		else $error("word closed without final item");

	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_rem_q <= 5'd16)
		else $error("leftover bit count out of range");

endmodule
